// ===== rtl/core/multi_slot_soft_timer_bank_unit_defines.svh =====
// assertion macros for the timer bank
`ifndef MULTI_SLOT_SOFT_TIMER_BANK_UNIT_DEFINES_SVH
`define MULTI_SLOT_SOFT_TIMER_BANK_UNIT_DEFINES_SVH

// same-cycle implication, checked on the rising clock edge out of reset
`define MSTB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MSTB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/mstb_pkg.sv =====
// shared codes and controller/datapath interface types for the timer bank
package mstb_pkg;

    localparam logic [1:0] MODE_TICK    = 2'd0;
    localparam logic [1:0] MODE_CREATE  = 2'd1;
    localparam logic [1:0] MODE_DESTROY = 2'd2;

    localparam logic [1:0] KIND_CREATE  = 2'd0;
    localparam logic [1:0] KIND_DESTROY = 2'd1;
    localparam logic [1:0] KIND_EXPIRY  = 2'd2;

    localparam int SLOT_ID_W  = 4;
    localparam int RESULT_CAP = 16;
    localparam int EVCNT_W    = 5;

    typedef struct packed {
        logic take;
        logic idx_inc;
        logic claim;
        logic crt_fail;
        logic dst;
        logic rd;
        logic drop;
        logic tick_upd;
        logic push_reply;
        logic push_held;
        logic push_last;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       zero_load;
        logic       idx_end;
        logic       cur_live;
        logic       cur_pend;
        logic       fire;
        logic       cap_ok;
        logic       held_vld;
        logic       out_free;
    } t_sts;

endpackage

// ===== rtl/core/mstb_ctrl.sv =====
// controller state machine for the timer bank
module mstb_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  mstb_pkg::t_sts  i_sts,
    output mstb_pkg::t_cmd  o_cmd,
    output logic            o_busy
);
    import mstb_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DISP  = 3'd1;
    localparam logic [2:0] S_CRT   = 3'd2;
    localparam logic [2:0] S_DST   = 3'd3;
    localparam logic [2:0] S_REPLY = 3'd4;
    localparam logic [2:0] S_TRD   = 3'd5;
    localparam logic [2:0] S_TEX   = 3'd6;
    localparam logic [2:0] S_TEND  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    t_cmd       cmd;
    logic       ev_new;

    assign ev_new = i_sts.fire && i_sts.cap_ok;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    cmd.take = 1'b1;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                case (i_sts.mode)
                    MODE_TICK:    n_state = S_TRD;
                    MODE_CREATE:  n_state = S_CRT;
                    MODE_DESTROY: n_state = S_DST;
                    default:      n_state = S_IDLE;
                endcase
            end
            S_CRT: begin
                if (i_sts.zero_load || i_sts.idx_end) begin
                    cmd.crt_fail = 1'b1;
                    n_state      = S_REPLY;
                end else if (!i_sts.cur_live) begin
                    cmd.claim = 1'b1;
                    n_state   = S_REPLY;
                end else begin
                    cmd.idx_inc = 1'b1;
                end
            end
            S_DST: begin
                cmd.dst = 1'b1;
                n_state = S_REPLY;
            end
            S_REPLY: begin
                if (i_sts.out_free) begin
                    cmd.push_reply = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_TRD: begin
                if (i_sts.idx_end) begin
                    n_state = S_TEND;
                end else if (!i_sts.cur_live) begin
                    cmd.idx_inc = 1'b1;
                end else if (i_sts.cur_pend) begin
                    cmd.drop    = 1'b1;
                    cmd.idx_inc = 1'b1;
                end else begin
                    cmd.rd  = 1'b1;
                    n_state = S_TEX;
                end
            end
            S_TEX: begin
                if (!(ev_new && i_sts.held_vld && !i_sts.out_free)) begin
                    cmd.tick_upd  = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    cmd.push_held = ev_new && i_sts.held_vld;
                    n_state       = S_TRD;
                end
            end
            S_TEND: begin
                if (!i_sts.held_vld) begin
                    n_state = S_IDLE;
                end else if (i_sts.out_free) begin
                    cmd.push_held = 1'b1;
                    cmd.push_last = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd  = cmd;
    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== rtl/core/mstb_dp.sv =====
// datapath for the timer bank: slot flags, count memories, decrementer, result register
module mstb_dp #(
    parameter int TIMER_SLOTS = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [1:0]                 i_mode,
    input  logic [3:0]                 i_slot,
    input  logic [31:0]                i_load_ticks,
    input  logic                       i_one_shot,
    input  mstb_pkg::t_cmd             i_cmd,
    output mstb_pkg::t_sts             o_sts,
    input  logic                       i_stall,
    output logic                       o_valid,
    output logic [1:0]                 o_reply_kind,
    output logic [3:0]                 o_slot_id,
    output logic                       o_ok,
    output logic                       o_last
);
    import mstb_pkg::*;

    localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
    localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

    logic [1:0]             r_mode;
    logic [3:0]             r_handle;
    logic [COUNT_WIDTH-1:0] r_load;
    logic                   r_once;
    logic [CNT_W-1:0]       r_idx;

    logic [TIMER_SLOTS-1:0] r_live;
    logic [TIMER_SLOTS-1:0] r_pend;
    logic [TIMER_SLOTS-1:0] r_one;

    logic [COUNT_WIDTH-1:0] r_rem_mem [TIMER_SLOTS];
    logic [COUNT_WIDTH-1:0] r_rel_mem [TIMER_SLOTS];
    logic [COUNT_WIDTH-1:0] r_rem_q;
    logic [COUNT_WIDTH-1:0] r_rel_q;

    logic [EVCNT_W-1:0]     r_ev_cnt;
    logic                   r_held_vld;
    logic [SLOT_ID_W-1:0]   r_held_id;

    logic [1:0]             r_rep_kind;
    logic [SLOT_ID_W-1:0]   r_rep_id;
    logic                   r_rep_ok;

    logic                   r_out_vld;
    logic [1:0]             r_out_kind;
    logic [SLOT_ID_W-1:0]   r_out_id;
    logic                   r_out_ok;
    logic                   r_out_last;

    logic [IDX_W-1:0]       cur;
    logic [IDX_W-1:0]       hidx;
    logic                   h_ok;
    logic [COUNT_WIDTH-1:0] dec;
    logic                   fire;
    logic                   ev_new;

    assign cur    = r_idx[IDX_W-1:0];
    assign hidx   = IDX_W'(r_handle);
    assign h_ok   = (32'(r_handle) < TIMER_SLOTS) && r_live[hidx];
    assign dec    = r_rem_q - COUNT_WIDTH'(1);
    assign fire   = (dec == '0);
    assign ev_new = fire && (r_ev_cnt < EVCNT_W'(RESULT_CAP));

    // latched request and walk index
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mode   <= i_mode;
            r_handle <= i_slot;
            r_load   <= COUNT_WIDTH'(i_load_ticks);
            r_once   <= i_one_shot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.take) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    // slot flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live <= '0;
            r_pend <= '0;
            r_one  <= '0;
        end else begin
            if (i_cmd.claim) begin
                r_live[cur] <= 1'b1;
                r_pend[cur] <= 1'b0;
                r_one[cur]  <= r_once;
            end
            if (i_cmd.dst && h_ok) begin
                r_pend[hidx] <= 1'b1;
            end
            if (i_cmd.drop) begin
                r_live[cur] <= 1'b0;
                r_pend[cur] <= 1'b0;
            end
            if (i_cmd.tick_upd && fire && r_one[cur]) begin
                r_live[cur] <= 1'b0;
            end
        end
    end

    // count memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.claim) begin
            r_rem_mem[cur] <= r_load;
        end else if (i_cmd.tick_upd) begin
            r_rem_mem[cur] <= fire ? r_rel_q : dec;
        end
        if (i_cmd.rd) begin
            r_rem_q <= r_rem_mem[cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.claim) begin
            r_rel_mem[cur] <= r_load;
        end
        if (i_cmd.rd) begin
            r_rel_q <= r_rel_mem[cur];
        end
    end

    // expiry held back until the next one or the end of the walk sets last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev_cnt   <= '0;
            r_held_vld <= 1'b0;
        end else if (i_cmd.take) begin
            r_ev_cnt   <= '0;
            r_held_vld <= 1'b0;
        end else if (i_cmd.tick_upd && ev_new) begin
            r_ev_cnt   <= r_ev_cnt + EVCNT_W'(1);
            r_held_vld <= 1'b1;
        end else if (i_cmd.push_last) begin
            r_held_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_upd && ev_new) begin
            r_held_id <= SLOT_ID_W'(cur);
        end
    end

    // create and destroy reply
    always_ff @(posedge i_clk) begin
        if (i_cmd.claim) begin
            r_rep_kind <= KIND_CREATE;
            r_rep_id   <= SLOT_ID_W'(cur);
            r_rep_ok   <= 1'b1;
        end else if (i_cmd.crt_fail) begin
            r_rep_kind <= KIND_CREATE;
            r_rep_id   <= '0;
            r_rep_ok   <= 1'b0;
        end else if (i_cmd.dst) begin
            r_rep_kind <= KIND_DESTROY;
            r_rep_id   <= r_handle;
            r_rep_ok   <= h_ok;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.push_reply || i_cmd.push_held) begin
            r_out_vld <= 1'b1;
        end else if (!i_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push_reply) begin
            r_out_kind <= r_rep_kind;
            r_out_id   <= r_rep_id;
            r_out_ok   <= r_rep_ok;
            r_out_last <= 1'b1;
        end else if (i_cmd.push_held) begin
            r_out_kind <= KIND_EXPIRY;
            r_out_id   <= r_held_id;
            r_out_ok   <= 1'b0;
            r_out_last <= i_cmd.push_last;
        end
    end

    always_comb begin
        o_sts.mode      = r_mode;
        o_sts.zero_load = (r_load == '0);
        o_sts.idx_end   = (r_idx == CNT_W'(TIMER_SLOTS));
        o_sts.cur_live  = r_live[cur];
        o_sts.cur_pend  = r_pend[cur];
        o_sts.fire      = fire;
        o_sts.cap_ok    = (r_ev_cnt < EVCNT_W'(RESULT_CAP));
        o_sts.held_vld  = r_held_vld;
        o_sts.out_free  = !r_out_vld || !i_stall;
    end

    assign o_valid      = r_out_vld;
    assign o_reply_kind = r_out_kind;
    assign o_slot_id    = r_out_id;
    assign o_ok         = r_out_ok;
    assign o_last       = r_out_last;

endmodule

// ===== rtl/core/multi_slot_soft_timer_bank_unit.sv =====
// top level of the timer bank
// Bank of TIMER_SLOTS countdown timers, one request at a time. A create scans the
// slots up to the first free one before it replies. A tick walks every slot in
// ascending order: a free slot is skipped, one marked for removal is freed, and a
// live slot takes a registered read of its count memory, then a decrement and write
// back through the single shared decrementer. Expiry events come out in slot order,
// at most sixteen per tick, and the walk pauses while an expiry waits on a stalled
// result register. o_stall is high from the cycle after a request is taken until its
// last result, if any, is queued.
`include "multi_slot_soft_timer_bank_unit_defines.svh"

module multi_slot_soft_timer_bank_unit #(
    parameter int TIMER_SLOTS = 16,
    parameter int COUNT_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_mode,
    input  logic [3:0]  i_slot,
    input  logic [31:0] i_load_ticks,
    input  logic        i_one_shot,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_reply_kind,
    output logic [3:0]  o_slot_id,
    output logic        o_ok,
    output logic        o_last
);
    import mstb_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;
    logic w_busy;

    mstb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy)
    );

    mstb_dp #(
        .TIMER_SLOTS (TIMER_SLOTS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (i_mode),
        .i_slot       (i_slot),
        .i_load_ticks (i_load_ticks),
        .i_one_shot   (i_one_shot),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_stall      (i_stall),
        .o_valid      (o_valid),
        .o_reply_kind (o_reply_kind),
        .o_slot_id    (o_slot_id),
        .o_ok         (o_ok),
        .o_last       (o_last)
    );

    assign o_stall = w_busy;

    `MSTB_ASSERT_NEXT(a_busy_after_take, i_valid && !o_stall, o_stall, "request taken but block not busy")
    `MSTB_ASSERT_NOW(a_no_push_on_stall, o_valid && i_stall, !(w_cmd.push_reply || w_cmd.push_held), "result pushed over a stalled result")
    `MSTB_ASSERT_NOW(a_expiry_not_ok, o_valid && (o_reply_kind == KIND_EXPIRY), !o_ok, "expiry event with ok set")

endmodule
